// File: hdl/dmw_pkg.sv
// Package for the displacement map warp: sizes, fixed-point constants, register codes.
`default_nettype none
package dmw_pkg;

  // frame store geometry
  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int PIXEL_W     = 32;

  // fixed point: amounts in 1/16 pixel, map bytes scaled by 255
  localparam int DIV_FULL    = 4080;
  localparam int DIV_HALF    = DIV_FULL / 2;
  localparam int DIV_BYTE    = DIV_FULL / 16;
  localparam int RECIP_SHIFT = 28;
  localparam int RECIP       = (1 << RECIP_SHIFT) / DIV_BYTE;
  localparam int RECIP_W     = 21;

  // datapath widths
  localparam int PROD_W = 26;   // (2*byte-255) * amount
  localparam int NUM_W  = 27;   // pos*4080 + product
  localparam int W_W    = 20;   // (|n| + half) / 16
  localparam int Q_W    = 13;   // quotient and clamped coordinate
  localparam int LIM_W  = 13;

  // configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_AMOUNT_X   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AMOUNT_Y   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_OFF_X  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_OFF_Y  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 4'd7;

  // item commands
  localparam logic CMD_LOAD     = 1'b0;
  localparam logic CMD_DISPLACE = 1'b1;

endpackage
`default_nettype wire

// File: hdl/dmw_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module dmw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule
`default_nettype wire

// File: hdl/displacement_map_warp.sv
// Displacement map warp: frame store, seven-stage sample pipeline ending in the store read.
//
// Usage
//   Input channel (in_valid/in_stall) carries one item per handshake. cmd = 0 stores
//   load_pixel at (pos_x, pos_y); cmd = 1 produces one output item, the stored pixel at
//   the displaced and clamped sample position, together with that position.
//   Output channel (out_valid/out_stall) carries out_pixel, sample_x, sample_y.
//   Registers must be written through cfg_valid/cfg_ready/cfg_index/cfg_data only while idle;
//   the block itself does not enforce this. cfg_ready is always high and unknown indexes are dropped.
// Timing
//   One item per clock sustained while out_stall is low. A displace item passes through six
//   stages of arithmetic (map test and multiply, sum, rounding add, reciprocal multiply,
//   correction, clamp) and the frame store read, whose registered data is the output
//   register. Loads go down the same stages and write the store at the read stage, so
//   loads and reads reach the single RAM port in arrival order.
// Stalls
//   Each stage moves on when the one after it is empty or moving, so bubbles close up;
//   a stalled output holds its item and in_stall rises only once all stages are full.
// Reset
//   rst clears the valid bits and sets the registers to their defaults. The frame store
//   is not cleared; pixels must be loaded before they are sampled.
`default_nettype none
module displacement_map_warp
  import dmw_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // configuration
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // input items
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  cmd,
  input  wire logic [7:0]            pos_x,
  input  wire logic [7:0]            pos_y,
  input  wire logic [31:0]           load_pixel,
  input  wire logic [7:0]            map_red,
  input  wire logic [7:0]            map_green,
  // result items
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [31:0]                out_pixel,
  output logic [7:0]                 sample_x,
  output logic [7:0]                 sample_y
);

  // ---------------------------------------------------------------------------
  // Configuration registers, index 0 = x axis, 1 = y axis
  // ---------------------------------------------------------------------------
  logic signed [15:0] amount   [2];
  logic        [8:0]  src_size [2];
  logic signed [12:0] map_off  [2];
  logic        [12:0] map_size [2];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      amount[0]   <= 16'sd320;
      amount[1]   <= 16'sd320;
      src_size[0] <= 9'd256;
      src_size[1] <= 9'd256;
      map_off[0]  <= '0;
      map_off[1]  <= '0;
      map_size[0] <= '0;
      map_size[1] <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_AMOUNT_X:   amount[0]   <= $signed(cfg_data);
        CFG_AMOUNT_Y:   amount[1]   <= $signed(cfg_data);
        CFG_SRC_WIDTH:  src_size[0] <= cfg_data[8:0];
        CFG_SRC_HEIGHT: src_size[1] <= cfg_data[8:0];
        CFG_MAP_OFF_X:  map_off[0]  <= $signed(cfg_data[12:0]);
        CFG_MAP_OFF_Y:  map_off[1]  <= $signed(cfg_data[12:0]);
        CFG_MAP_WIDTH:  map_size[0] <= cfg_data[12:0];
        CFG_MAP_HEIGHT: map_size[1] <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // clamp limit minus one: source size held to 1..MAX on each axis
  logic [LIM_W-1:0] lim_m1 [2];

  always_comb begin
    logic [LIM_W-1:0] lim;
    logic [LIM_W-1:0] max_dim;
    for (int a = 0; a < 2; a++) begin
      max_dim = (a == 0) ? LIM_W'(MAX_WIDTH) : LIM_W'(MAX_HEIGHT);
      lim = (LIM_W'(src_size[a]) > max_dim) ? max_dim : LIM_W'(src_size[a]);
      if (lim == '0) begin
        lim = LIM_W'(1);
      end
      lim_m1[a] = lim - LIM_W'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage advance: a stage takes a new item when empty or when its item moves on
  // ---------------------------------------------------------------------------
  logic [7:1] valid;
  logic [7:1] take;
  logic       s6_cmd;

  always_comb begin
    take[7] = !valid[7] || !out_stall;
    for (int k = 6; k >= 1; k--) begin
      take[k] = !valid[k] || take[k+1];
    end
  end

  assign in_stall = !take[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (take[1]) valid[1] <= in_valid;
      for (int k = 2; k <= 6; k++) begin
        if (take[k]) valid[k] <= valid[k-1];
      end
      // loads end at the store and leave no result
      if (take[7]) valid[7] <= valid[6] && (s6_cmd == CMD_DISPLACE);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: map rectangle test and (2*byte - 255) * amount
  // ---------------------------------------------------------------------------
  logic [7:0] in_pos  [2];
  logic [7:0] in_byte [2];

  assign in_pos[0]  = pos_x;
  assign in_pos[1]  = pos_y;
  assign in_byte[0] = map_red;
  assign in_byte[1] = map_green;

  logic                     in_inside;
  logic signed [PROD_W-1:0] prod_c [2];

  always_comb begin
    logic signed [13:0] mpos;
    logic signed [9:0]  diff;
    in_inside = 1'b1;
    for (int a = 0; a < 2; a++) begin
      mpos = $signed({6'b0, in_pos[a]}) + 14'(map_off[a]);
      if (mpos[13] || (mpos[12:0] >= map_size[a])) begin
        in_inside = 1'b0;
      end
      diff = $signed({1'b0, in_byte[a], 1'b0}) - 10'sd255;
      prod_c[a] = diff * amount[a];
    end
  end

  logic                     s1_cmd;
  logic [7:0]               s1_pos [2];
  logic [PIXEL_W-1:0]       s1_pixel;
  logic                     s1_inside;
  logic signed [PROD_W-1:0] s1_prod [2];

  always_ff @(posedge clk) begin
    if (take[1]) begin
      s1_cmd    <= cmd;
      s1_pos    <= in_pos;
      s1_pixel  <= load_pixel;
      s1_inside <= in_inside;
      s1_prod   <= prod_c;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: numerator n = pos*4080 + product (product only inside the map)
  // ---------------------------------------------------------------------------
  logic signed [NUM_W-1:0] n_c [2];

  always_comb begin
    logic [19:0] pos_term;
    for (int a = 0; a < 2; a++) begin
      pos_term = {s1_pos[a], 12'b0} - {8'b0, s1_pos[a], 4'b0};   // pos * 4080
      n_c[a] = $signed({7'b0, pos_term}) + (s1_inside ? NUM_W'(s1_prod[a]) : '0);
    end
  end

  logic                    s2_cmd;
  logic [7:0]              s2_pos [2];
  logic [PIXEL_W-1:0]      s2_pixel;
  logic signed [NUM_W-1:0] s2_n [2];

  always_ff @(posedge clk) begin
    if (take[2]) begin
      s2_cmd   <= s1_cmd;
      s2_pos   <= s1_pos;
      s2_pixel <= s1_pixel;
      s2_n     <= n_c;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: w = (|n| + 2040) / 16; negation folded into the one add
  // ---------------------------------------------------------------------------
  logic [W_W-1:0] w_c   [2];
  logic           neg_c [2];

  always_comb begin
    logic [NUM_W-1:0] v;
    for (int a = 0; a < 2; a++) begin
      neg_c[a] = s2_n[a][NUM_W-1];
      v = neg_c[a] ? (~s2_n[a] + NUM_W'(DIV_HALF + 1)) : (s2_n[a] + NUM_W'(DIV_HALF));
      w_c[a] = v[W_W+3:4];
    end
  end

  logic               s3_cmd;
  logic [7:0]         s3_pos [2];
  logic [PIXEL_W-1:0] s3_pixel;
  logic [W_W-1:0]     s3_w   [2];
  logic               s3_neg [2];

  always_ff @(posedge clk) begin
    if (take[3]) begin
      s3_cmd   <= s2_cmd;
      s3_pos   <= s2_pos;
      s3_pixel <= s2_pixel;
      s3_w     <= w_c;
      s3_neg   <= neg_c;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: estimate w / 255 by reciprocal; estimate is exact or one low
  // ---------------------------------------------------------------------------
  logic [Q_W-1:0] q0_c [2];

  always_comb begin
    logic [W_W+RECIP_W-1:0] mul;
    for (int a = 0; a < 2; a++) begin
      mul = (W_W+RECIP_W)'(s3_w[a]) * (W_W+RECIP_W)'(RECIP);
      q0_c[a] = mul[RECIP_SHIFT +: Q_W];
    end
  end

  logic               s4_cmd;
  logic [7:0]         s4_pos [2];
  logic [PIXEL_W-1:0] s4_pixel;
  logic [W_W-1:0]     s4_w   [2];
  logic [Q_W-1:0]     s4_q0  [2];
  logic               s4_neg [2];

  always_ff @(posedge clk) begin
    if (take[4]) begin
      s4_cmd   <= s3_cmd;
      s4_pos   <= s3_pos;
      s4_pixel <= s3_pixel;
      s4_w     <= s3_w;
      s4_q0    <= q0_c;
      s4_neg   <= s3_neg;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: remainder check, bump quotient when remainder reaches 255
  // ---------------------------------------------------------------------------
  logic [W_W:0]   rem_c [2];
  logic [Q_W-1:0] q_c   [2];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      rem_c[a] = (W_W+1)'(s4_w[a]) - (W_W+1)'(s4_q0[a]) * (W_W+1)'(DIV_BYTE);
      q_c[a] = s4_q0[a] + Q_W'(rem_c[a] >= (W_W+1)'(DIV_BYTE));
    end
  end

  logic               s5_cmd;
  logic [7:0]         s5_pos [2];
  logic [PIXEL_W-1:0] s5_pixel;
  logic [Q_W-1:0]     s5_q   [2];
  logic               s5_neg [2];

  always_ff @(posedge clk) begin
    if (take[5]) begin
      s5_cmd   <= s4_cmd;
      s5_pos   <= s4_pos;
      s5_pixel <= s4_pixel;
      s5_q     <= q_c;
      s5_neg   <= s4_neg;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: clamp to the source; a load keeps its own coordinate here
  // ---------------------------------------------------------------------------
  logic [Q_W-1:0] s_c [2];
  logic           wr_ok_c;

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      if (s5_cmd == CMD_LOAD) begin
        s_c[a] = Q_W'(s5_pos[a]);
      end else if (s5_neg[a]) begin
        s_c[a] = '0;                    // negative sample clamps to zero
      end else if (s5_q[a] > Q_W'(lim_m1[a])) begin
        s_c[a] = Q_W'(lim_m1[a]);
      end else begin
        s_c[a] = s5_q[a];
      end
    end
    wr_ok_c = (Q_W'(s5_pos[0]) < Q_W'(MAX_WIDTH)) && (Q_W'(s5_pos[1]) < Q_W'(MAX_HEIGHT));
  end

  logic               s6_wr_ok;
  logic [PIXEL_W-1:0] s6_pixel;
  logic [Q_W-1:0]     s6_s [2];

  always_ff @(posedge clk) begin
    if (take[6]) begin
      s6_cmd   <= s5_cmd;
      s6_wr_ok <= wr_ok_c;
      s6_pixel <= s5_pixel;
      s6_s     <= s_c;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 7: frame store access; read data register is the output register
  // ---------------------------------------------------------------------------
  logic              ram_en;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;

  assign ram_en   = take[7] && valid[6];
  assign ram_we   = (s6_cmd == CMD_LOAD) && s6_wr_ok;
  assign ram_addr = ADDR_W'(32'(s6_s[1]) * 32'(MAX_WIDTH) + 32'(s6_s[0]));

  dmw_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (s6_pixel),
    .rdata (out_pixel)
  );

  logic [7:0] s7_s [2];

  always_ff @(posedge clk) begin
    if (take[7]) begin
      s7_s[0] <= s6_s[0][7:0];
      s7_s[1] <= s6_s[1][7:0];
    end
  end

  assign out_valid = valid[7];
  assign sample_x  = s7_s[0];
  assign sample_y  = s7_s[1];

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // input only stalls when every stage holds an item
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (&valid))
    else $error("input stalled with a bubble in the pipeline");

  // reciprocal estimate is never more than one low
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    valid[4] |-> (rem_c[0] < (W_W+1)'(2 * DIV_BYTE)) && (rem_c[1] < (W_W+1)'(2 * DIV_BYTE)))
    else $error("quotient correction out of range");

  // a displace sample lies inside the source rectangle
  a_clamp: assert property (@(posedge clk) disable iff (rst)
    (valid[6] && (s6_cmd == CMD_DISPLACE)) |->
      (s6_s[0] <= Q_W'(lim_m1[0])) && (s6_s[1] <= Q_W'(lim_m1[1])))
    else $error("sample outside source");

  // a displace leaving the read stage becomes a result next cycle
  a_result: assert property (@(posedge clk) disable iff (rst)
    (take[7] && valid[6] && (s6_cmd == CMD_DISPLACE)) |=> out_valid)
    else $error("displace item lost at the store");

  // no result straight after a reset cycle
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule
`default_nettype wire
